>>> sv/bitmap_id_allocator_assert.svh
// Assertion macros for the bitmap identifier allocator.
// Included by the top level; no other dependencies.
`ifndef BITMAP_ID_ALLOCATOR_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BIA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitmap_id_allocator: assertion failed");
`define BIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitmap_id_allocator: assertion failed");
`else
`define BIA_ASSERT_SAME(label, clk, rst, ante, cons)
`define BIA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/bia_pkg.sv
// Shared constants, codes and control structs of the bitmap identifier allocator.
// No dependencies.
package bia_pkg;

  localparam int MAP_WORDS = 128;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int IDX_W     = ADDR_W + BIT_W;
  localparam int LIM_W     = 17;
  localparam int ID_W      = 16;
  localparam int COUNT_W   = 13;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam logic [LIM_W-1:0] CAPACITY  = LIM_W'(MAP_WORDS * WORD_BITS);
  localparam logic [LIM_W-1:0] ID_SPACE  = LIM_W'(65536);
  localparam logic [ID_W-1:0]    BASE_RESET  = ID_W'(300);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);

  localparam logic [CFG_IDX_W-1:0] CFG_ID_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ID_COUNT = CFG_IDX_W'(1);

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANTED      = 2'd0,
    ST_NONE_FREE    = 2'd1,
    ST_RELEASED     = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic rd_scan;
    logic rd_rel;
    logic ptr_inc;
    logic wr_alloc;
    logic wr_rel;
    logic res_grant;
    logic res_none;
    logic res_rel;
    logic res_oor;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic kind_rel;
    logic rel_ok;
    logic word_full;
    logic idx_ok;
    logic ptr_last;
    logic out_busy;
  } stat_t;

endpackage

>>> sv/bia_if.sv
// Channel interfaces of the bitmap identifier allocator: request, response, config.
// Depends on bia_pkg.
interface bia_req_if import bia_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [ID_W-1:0] release_id;
  modport source (output valid, kind, release_id, input ready);
  modport sink   (input valid, kind, release_id, output ready);
endinterface

interface bia_rsp_if import bia_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] granted_id;
  status_t         status;
  modport source (output valid, granted_id, status, input ready);
  modport sink   (input valid, granted_id, status, output ready);
endinterface

interface bia_cfg_if import bia_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/bia_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

>>> sv/bia_ctrl.sv
// Controller of the bitmap identifier allocator: sequences scan, release and response.
// Depends on bia_pkg.
module bia_ctrl import bia_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t st,
  output cmd_t  cmd
);
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_SCAN_RD  = 6'b000100,
    S_SCAN_CHK = 6'b001000,
    S_REL_WR   = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  state_t state, state_next;

  assign req_ready = !rst && (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!st.kind_rel) begin
          state_next = S_SCAN_RD;
        end else if (st.rel_ok) begin
          cmd.rd_rel = 1'b1;
          state_next = S_REL_WR;
        end else begin
          cmd.res_oor = 1'b1;
          state_next  = S_RESP;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_next  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!st.word_full) begin
          if (st.idx_ok) begin
            cmd.wr_alloc  = 1'b1;
            cmd.res_grant = 1'b1;
          end else begin
            cmd.res_none = 1'b1;
          end
          state_next = S_RESP;
        end else if (st.ptr_last) begin
          cmd.res_none = 1'b1;
          state_next   = S_RESP;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_REL_WR: begin
        cmd.wr_rel  = 1'b1;
        cmd.res_rel = 1'b1;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

>>> sv/bia_dp.sv
// Datapath of the bitmap identifier allocator: config, request, bitmap RAM, result.
// Depends on bia_pkg, bia_if and bia_ram.
module bia_dp import bia_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_kind,
  input  logic [ID_W-1:0] req_release_id,
  bia_cfg_if.sink         cfg,
  bia_rsp_if.source       rsp,
  input  cmd_t            cmd,
  output stat_t           st
);
  logic [ID_W-1:0]    id_base;
  logic [COUNT_W-1:0] id_count;
  logic [ID_W-1:0]    base_q;
  logic [LIM_W-1:0]   limit_q;
  logic               kind_q;
  logic [ID_W-1:0]    rid_q;
  logic [ADDR_W-1:0]  ptr;
  logic [MAP_WORDS-1:0] vld;
  logic               rd_vld_q;
  logic [ID_W-1:0]    res_id;
  status_t            res_status;
  logic               out_valid;
  logic [ID_W-1:0]    out_id;
  status_t            out_status;

  logic [LIM_W-1:0]     room, lim_a, lim_b;
  logic [ID_W-1:0]      off;
  logic [ADDR_W-1:0]    rel_word;
  logic [BIT_W-1:0]     rel_bit;
  logic [WORD_BITS-1:0] ram_rdata, word;
  logic [BIT_W-1:0]     free_bit;
  logic [IDX_W-1:0]     idx;
  logic                 rd_en, wr_en;
  logic [ADDR_W-1:0]    rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // config port
  assign cfg.ready = !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      id_base  <= BASE_RESET;
      id_count <= COUNT_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_ID_BASE) begin
        id_base <= cfg.data[ID_W-1:0];
      end else if (cfg.index == CFG_ID_COUNT) begin
        id_count <= cfg.data[COUNT_W-1:0];
      end
    end
  end

  // effective count: min(id_count, capacity, id space above base)
  always_comb begin
    room  = ID_SPACE - LIM_W'(id_base);
    lim_a = LIM_W'(id_count);
    if (lim_a > CAPACITY) begin
      lim_a = CAPACITY;
    end
    lim_b = (lim_a > room) ? room : lim_a;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_q  <= id_base;
      limit_q <= lim_b;
      kind_q  <= req_kind;
      rid_q   <= req_release_id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ptr <= '0;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + ADDR_W'(1);
    end
  end

  // release address
  assign off      = rid_q - base_q;
  assign rel_word = ADDR_W'(off >> BIT_W);
  assign rel_bit  = off[BIT_W-1:0];

  // scan word and its lowest clear bit
  assign word = rd_vld_q ? ram_rdata : '0;
  always_comb begin
    free_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        free_bit = BIT_W'(i);
      end
    end
  end
  assign idx = {ptr, free_bit};

  assign st.kind_rel  = (kind_q == KIND_RELEASE);
  assign st.rel_ok    = (rid_q >= base_q) && (LIM_W'(off) < limit_q);
  assign st.word_full = &word;
  assign st.idx_ok    = LIM_W'(idx) < limit_q;
  assign st.ptr_last  = (ptr == ADDR_W'(MAP_WORDS - 1));
  assign st.out_busy  = out_valid && !rsp.ready;

  // bitmap RAM, entries not yet written read as free
  assign rd_en   = cmd.rd_scan || cmd.rd_rel;
  assign rd_addr = cmd.rd_rel ? rel_word : ptr;
  assign wr_en   = cmd.wr_alloc || cmd.wr_rel;
  assign wr_addr = cmd.wr_rel ? rel_word : ptr;
  assign wr_data = cmd.wr_rel ? (word & ~(WORD_BITS'(1) << rel_bit))
                              : (word | (WORD_BITS'(1) << free_bit));

  bia_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld[rd_addr];
      end
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.res_grant) begin
      res_id     <= base_q + ID_W'(idx);
      res_status <= ST_GRANTED;
    end else if (cmd.res_none) begin
      res_id     <= '0;
      res_status <= ST_NONE_FREE;
    end else if (cmd.res_rel) begin
      res_id     <= '0;
      res_status <= ST_RELEASED;
    end else if (cmd.res_oor) begin
      res_id     <= '0;
      res_status <= ST_OUT_OF_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_id     <= res_id;
      out_status <= res_status;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.granted_id = out_id;
  assign rsp.status     = out_status;
endmodule

>>> sv/bitmap_id_allocator.sv
// Bitmap identifier allocator, lowest free identifier first.
// Usage:
//   req : kind (0 allocate, 1 release) and release_id; one beat per request.
//   rsp : one beat per request, granted_id and status (granted, none free,
//         released, release out of range).
//   cfg : write beat of register index and data; index 0 id_base, index 1
//         id_count, others ignored. Write only while no request is in flight.
// One request is handled at a time. The bitmap RAM has one read port and
// the scan reads one word at a time, a read state then a check state per
// word, up to the first word with a clear bit; a release reads its word and
// writes it back, and an out-of-range release goes straight to the response.
// The response sits in an output register; while the receiver stalls,
// the block finishes the next request and holds its result until the
// register frees. Reset (rst, synchronous) frees every identifier at once
// through per-word valid bits and restores id_base 300, id_count 4096.
// Depends on bia_pkg, bia_if, bia_ctrl, bia_dp and the assertion header.
`include "bitmap_id_allocator_assert.svh"
module bitmap_id_allocator import bia_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bia_req_if.sink   req,
  bia_rsp_if.source rsp,
  bia_cfg_if.sink   cfg
);
  cmd_t  cmd;
  stat_t st;

  bia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  bia_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_kind       (req.kind),
    .req_release_id (req.release_id),
    .cfg            (cfg),
    .rsp            (rsp),
    .cmd            (cmd),
    .st             (st)
  );

  `BIA_ASSERT_NEXT(a_busy_after_req, clk, rst, req.valid && req.ready, !req.ready)
  `BIA_ASSERT_SAME(a_id_zero, clk, rst, rsp.valid && (rsp.status != ST_GRANTED), rsp.granted_id == '0)
  `BIA_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.out_load, !rsp.valid || rsp.ready)
  `BIA_ASSERT_SAME(a_write_idle_req, clk, rst, cmd.wr_alloc || cmd.wr_rel, !req.ready)
endmodule
